// File: hw/rtl/fci_pkg.sv
// Shared types and constants for the planar FABRIK chain iteration block.
// Used by fci_ctrl, fci_datapath and fabrik_chain_iteration; depends on nothing.
package fci_pkg;

  localparam int DEF_JOINT_COUNT = 4;
  localparam int DEF_COORD_WIDTH = 24;

  localparam int NUM_SEG_REGS = 3;
  localparam int SEG_W        = 16;
  localparam int CFG_IDX_W    = 2;
  localparam logic [SEG_W-1:0] SEG_RESET = 16'd12800;

  // Joint numbers travel in three bits, enough for up to eight joints.
  localparam int IDX_W = 3;

  localparam int MAG_W  = 33;
  localparam int MUL_W  = 31;
  localparam int PROD_W = 62;
  localparam int ACC_W  = 63;
  localparam int RAD_W  = 64;
  localparam int ROOT_W = 32;
  localparam int REM_W  = 34;
  localparam int Q_W    = 17;
  localparam int TOT_W  = 18;

  localparam int SQRT_ITERS = 32;
  localparam int DIV_ITERS  = 17;
  localparam int CNT_W      = 5;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_IN,
    OP_MUL_X,
    OP_MUL_Y,
    OP_MUL_T,
    OP_REACH_CMP,
    OP_WR_ROOT,
    OP_WR_TGT,
    OP_READ,
    OP_LATCH_BASE,
    OP_LATCH_VEC,
    OP_SHIFT,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SCALE_X,
    OP_SCALE_Y,
    OP_WR_PLACE,
    OP_OUT_LOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [IDX_W-1:0] idx;
    logic [IDX_W-1:0] seg;
  } dp_cmd_t;

  typedef struct packed {
    logic far;
    logic zero;
    logic mag_lo;
    logic mag_hi;
  } dp_status_t;

  typedef enum logic [22:0] {
    S_IDLE  = 23'h000001,
    S_MX    = 23'h000002,
    S_MY    = 23'h000004,
    S_MT    = 23'h000008,
    S_RC    = 23'h000010,
    S_BR    = 23'h000020,
    S_RDO   = 23'h000040,
    S_RDB   = 23'h000080,
    S_LAT   = 23'h000100,
    S_SHIFT = 23'h000200,
    S_SQX   = 23'h000400,
    S_SQY   = 23'h000800,
    S_SQI   = 23'h001000,
    S_SQRT  = 23'h002000,
    S_DVI   = 23'h004000,
    S_DIV   = 23'h008000,
    S_SCX   = 23'h010000,
    S_SCY   = 23'h020000,
    S_WR    = 23'h040000,
    S_W0    = 23'h080000,
    S_ORD   = 23'h100000,
    S_OLD   = 23'h200000,
    S_OWAIT = 23'h400000
  } state_t;

endpackage

// File: hw/rtl/fci_datapath.sv
// Datapath of the FABRIK chain iteration: joint store, segment registers,
// shared multiplier, bit-serial square root and divider. Depends on fci_pkg.
module fci_datapath #(
  parameter int JOINT_COUNT = fci_pkg::DEF_JOINT_COUNT,
  parameter int COORD_WIDTH = fci_pkg::DEF_COORD_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fci_pkg::dp_cmd_t                 cmd,
  output fci_pkg::dp_status_t              status,
  input  logic [COORD_WIDTH-1:0]           root_x,
  input  logic [COORD_WIDTH-1:0]           root_y,
  input  logic [COORD_WIDTH-1:0]           target_x,
  input  logic [COORD_WIDTH-1:0]           target_y,
  input  logic                             cfg_we,
  input  logic [fci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fci_pkg::SEG_W-1:0]        cfg_data,
  output logic [fci_pkg::IDX_W-1:0]        out_index,
  output logic [COORD_WIDTH-1:0]           out_x,
  output logic [COORD_WIDTH-1:0]           out_y,
  output logic                             out_stretched,
  output logic                             out_last
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = COORD_WIDTH + 1;
  localparam int SW = COORD_WIDTH + 2;
  localparam int JW = $clog2(JOINT_COUNT);
  localparam logic [fci_pkg::IDX_W-1:0] LAST_IDX = fci_pkg::IDX_W'(JOINT_COUNT - 1);

  logic [W-1:0] jx [JOINT_COUNT];
  logic [W-1:0] jy [JOINT_COUNT];
  logic [fci_pkg::SEG_W-1:0] seg_reg [fci_pkg::NUM_SEG_REGS];

  logic [W-1:0] rx, ry, tx, ty;
  logic [W-1:0] rd_x, rd_y, oth_x, oth_y, base_x, base_y, nx;
  logic         far;
  logic [fci_pkg::MAG_W-1:0]  ax, ay, mag_or;
  logic                       neg_x, neg_y;
  logic [fci_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic [fci_pkg::PROD_W-1:0] mul_p;
  logic [fci_pkg::ACC_W-1:0]  acc, acc_sum;
  logic [fci_pkg::RAD_W-1:0]  rad;
  logic [fci_pkg::ROOT_W-1:0] root, drx, dry, drx_next, dry_next;
  logic [fci_pkg::REM_W-1:0]  rem, rem_next;
  logic [fci_pkg::Q_W-1:0]    qx, qy, nbx, nby, rp;
  logic [fci_pkg::TOT_W-1:0]  tot;
  logic [fci_pkg::SEG_W-1:0]  seg_sel;

  logic [W-1:0]  va_x, va_y, vb_x, vb_y;
  logic [DW-1:0] dvx, dvy, mvx, mvy;
  logic [fci_pkg::REM_W+1:0] rem_w, trial;
  logic sq_ge, dx_ge, dy_ge;
  logic [fci_pkg::ROOT_W:0] tdx, tdy, dsub_x, dsub_y;
  logic [fci_pkg::REM_W+1:0] rsub;
  logic [33:0] rnd;
  logic [W-1:0] place_x, place_y;

  function automatic logic [W-1:0] place(input logic [W-1:0] base,
                                         input logic [fci_pkg::Q_W-1:0] p,
                                         input logic neg);
    logic signed [SW-1:0] off, sum, cmax, cmin;
    off  = $signed({{(SW-fci_pkg::Q_W){1'b0}}, p});
    cmax = $signed({3'b000, {(W-1){1'b1}}});
    cmin = $signed({3'b111, {(W-1){1'b0}}});
    if (neg) begin
      off = -off;
    end
    sum = $signed({{2{base[W-1]}}, base}) + off;
    if (sum > cmax) begin
      return cmax[W-1:0];
    end else if (sum < cmin) begin
      return cmin[W-1:0];
    end
    return sum[W-1:0];
  endfunction

  // Vector between two points: the inputs on load, stored joints otherwise.
  always_comb begin
    if (cmd.op == fci_pkg::OP_LOAD_IN) begin
      va_x = target_x;
      va_y = target_y;
      vb_x = root_x;
      vb_y = root_y;
    end else begin
      va_x = oth_x;
      va_y = oth_y;
      vb_x = rd_x;
      vb_y = rd_y;
    end
    dvx = {va_x[W-1], va_x} - {vb_x[W-1], vb_x};
    dvy = {va_y[W-1], va_y} - {vb_y[W-1], vb_y};
    mvx = dvx[DW-1] ? -dvx : dvx;
    mvy = dvy[DW-1] ? -dvy : dvy;
  end

  always_comb begin
    tot = '0;
    for (int i = 0; i < fci_pkg::NUM_SEG_REGS; i++) begin
      if (i < JOINT_COUNT - 1) begin
        tot = tot + fci_pkg::TOT_W'(seg_reg[i]);
      end
    end
    if (cmd.seg < fci_pkg::IDX_W'(fci_pkg::NUM_SEG_REGS)) begin
      seg_sel = seg_reg[cmd.seg[fci_pkg::CFG_IDX_W-1:0]];
    end else begin
      seg_sel = '0;
    end
  end

  always_comb begin
    case (cmd.op)
      fci_pkg::OP_MUL_X: begin
        mul_a = ax[fci_pkg::MUL_W-1:0];
        mul_b = ax[fci_pkg::MUL_W-1:0];
      end
      fci_pkg::OP_MUL_Y, fci_pkg::OP_SQRT_INIT: begin
        mul_a = ay[fci_pkg::MUL_W-1:0];
        mul_b = ay[fci_pkg::MUL_W-1:0];
      end
      fci_pkg::OP_MUL_T: begin
        mul_a = fci_pkg::MUL_W'(tot);
        mul_b = fci_pkg::MUL_W'(tot);
      end
      fci_pkg::OP_SCALE_X: begin
        mul_a = fci_pkg::MUL_W'(qx);
        mul_b = fci_pkg::MUL_W'(seg_sel);
      end
      fci_pkg::OP_SCALE_Y: begin
        mul_a = fci_pkg::MUL_W'(qy);
        mul_b = fci_pkg::MUL_W'(seg_sel);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    mag_or  = ax | ay;
    acc_sum = acc + {1'b0, mul_p};
    // Square root: two radicand bits per step, one root bit out.
    rem_w    = {rem, rad[fci_pkg::RAD_W-1 -: 2]};
    trial    = {2'b00, root, 2'b01};
    sq_ge    = rem_w >= trial;
    rsub     = rem_w - trial;
    rem_next = sq_ge ? rsub[fci_pkg::REM_W-1:0] : rem_w[fci_pkg::REM_W-1:0];
    // Restoring division, one quotient bit per step on each component.
    tdx    = {drx, nbx[fci_pkg::Q_W-1]};
    tdy    = {dry, nby[fci_pkg::Q_W-1]};
    dx_ge  = tdx >= {1'b0, root};
    dy_ge  = tdy >= {1'b0, root};
    dsub_x = tdx - {1'b0, root};
    dsub_y = tdy - {1'b0, root};
    drx_next = dx_ge ? dsub_x[fci_pkg::ROOT_W-1:0] : tdx[fci_pkg::ROOT_W-1:0];
    dry_next = dy_ge ? dsub_y[fci_pkg::ROOT_W-1:0] : tdy[fci_pkg::ROOT_W-1:0];
    // Offset rounded half away from zero, applied to the magnitude.
    rnd     = {1'b0, mul_p[32:0]} + 34'd32768;
    rp      = rnd[32:16];
    place_x = place(base_x, rp, neg_x);
    place_y = place(base_y, rp, neg_y);
  end

  assign status.far    = far;
  assign status.zero   = (mag_or == '0);
  assign status.mag_hi = |mag_or[fci_pkg::MAG_W-1:31];
  assign status.mag_lo = ~|mag_or[fci_pkg::MAG_W-1:30];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fci_pkg::NUM_SEG_REGS; i++) begin
        seg_reg[i] <= fci_pkg::SEG_RESET;
      end
    end else if (cfg_we && cfg_index < fci_pkg::CFG_IDX_W'(fci_pkg::NUM_SEG_REGS)) begin
      seg_reg[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < JOINT_COUNT; i++) begin
        jx[i] <= '0;
        jy[i] <= '0;
      end
      far <= 1'b0;
    end else begin
      case (cmd.op)
        fci_pkg::OP_WR_ROOT: begin
          jx[cmd.idx[JW-1:0]] <= rx;
          jy[cmd.idx[JW-1:0]] <= ry;
        end
        fci_pkg::OP_WR_TGT: begin
          jx[cmd.idx[JW-1:0]] <= tx;
          jy[cmd.idx[JW-1:0]] <= ty;
        end
        fci_pkg::OP_WR_PLACE: begin
          jx[cmd.idx[JW-1:0]] <= nx;
          jy[cmd.idx[JW-1:0]] <= place_y;
        end
        fci_pkg::OP_REACH_CMP: begin
          far <= (|ax[fci_pkg::MAG_W-1:31]) || (|ay[fci_pkg::MAG_W-1:31]) ||
                 (acc > {1'b0, mul_p});
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    mul_p <= fci_pkg::PROD_W'(mul_a) * fci_pkg::PROD_W'(mul_b);
    case (cmd.op)
      fci_pkg::OP_LOAD_IN: begin
        rx    <= root_x;
        ry    <= root_y;
        tx    <= target_x;
        ty    <= target_y;
        ax    <= {{(fci_pkg::MAG_W-W){1'b0}}, mvx[W-1:0]};
        ay    <= {{(fci_pkg::MAG_W-W){1'b0}}, mvy[W-1:0]};
        neg_x <= dvx[DW-1];
        neg_y <= dvy[DW-1];
      end
      fci_pkg::OP_MUL_Y:    acc <= {1'b0, mul_p};
      fci_pkg::OP_MUL_T:    acc <= acc_sum;
      fci_pkg::OP_READ: begin
        rd_x  <= jx[cmd.idx[JW-1:0]];
        rd_y  <= jy[cmd.idx[JW-1:0]];
        oth_x <= rd_x;
        oth_y <= rd_y;
      end
      fci_pkg::OP_LATCH_BASE: begin
        base_x <= rd_x;
        base_y <= rd_y;
      end
      fci_pkg::OP_LATCH_VEC: begin
        base_x <= rd_x;
        base_y <= rd_y;
        ax     <= {{(fci_pkg::MAG_W-W){1'b0}}, mvx[W-1:0]};
        ay     <= {{(fci_pkg::MAG_W-W){1'b0}}, mvy[W-1:0]};
        neg_x  <= dvx[DW-1];
        neg_y  <= dvy[DW-1];
      end
      fci_pkg::OP_SHIFT: begin
        if (mag_or == '0) begin
          qx <= '0;
          qy <= '0;
        end else if (|mag_or[fci_pkg::MAG_W-1:31]) begin
          ax <= ax >> 1;
          ay <= ay >> 1;
        end else if (~|mag_or[fci_pkg::MAG_W-1:30]) begin
          ax <= ax << 1;
          ay <= ay << 1;
        end
      end
      fci_pkg::OP_SQRT_INIT: begin
        rad  <= {1'b0, acc_sum};
        root <= '0;
        rem  <= '0;
      end
      fci_pkg::OP_SQRT_STEP: begin
        rem  <= rem_next;
        root <= {root[fci_pkg::ROOT_W-2:0], sq_ge};
        rad  <= rad << 2;
      end
      fci_pkg::OP_DIV_INIT: begin
        drx <= fci_pkg::ROOT_W'(ax[30:1]);
        dry <= fci_pkg::ROOT_W'(ay[30:1]);
        nbx <= {ax[0], {(fci_pkg::Q_W-1){1'b0}}};
        nby <= {ay[0], {(fci_pkg::Q_W-1){1'b0}}};
        qx  <= '0;
        qy  <= '0;
      end
      fci_pkg::OP_DIV_STEP: begin
        drx <= drx_next;
        dry <= dry_next;
        nbx <= nbx << 1;
        nby <= nby << 1;
        qx  <= {qx[fci_pkg::Q_W-2:0], dx_ge};
        qy  <= {qy[fci_pkg::Q_W-2:0], dy_ge};
      end
      fci_pkg::OP_SCALE_Y:  nx <= place_x;
      fci_pkg::OP_OUT_LOAD: begin
        out_index     <= cmd.idx;
        out_x         <= rd_x;
        out_y         <= rd_y;
        out_stretched <= far;
        out_last      <= (cmd.idx == LAST_IDX);
      end
      default: begin
      end
    endcase
  end

endmodule

// File: hw/rtl/fci_ctrl.sv
// Controller of the FABRIK chain iteration: sequences the passes, the
// normalisations and the result transfers. Depends on fci_pkg.
module fci_ctrl #(
  parameter int JOINT_COUNT = fci_pkg::DEF_JOINT_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output fci_pkg::dp_cmd_t    cmd,
  input  fci_pkg::dp_status_t status
);

  localparam logic [fci_pkg::IDX_W-1:0] LAST_IDX = fci_pkg::IDX_W'(JOINT_COUNT - 1);
  localparam logic [fci_pkg::IDX_W-1:0] ONE_IDX  = fci_pkg::IDX_W'(1);

  fci_pkg::state_t state, state_next;
  logic [fci_pkg::IDX_W-1:0] idx, idx_next, base_idx;
  logic [fci_pkg::CNT_W-1:0] cnt, cnt_next;
  logic bwd, bwd_next;

  assign in_ready  = (state == fci_pkg::S_IDLE);
  assign out_valid = (state == fci_pkg::S_OWAIT);
  assign base_idx  = bwd ? idx + 1'b1 : idx - 1'b1;

  always_comb begin
    state_next = state;
    idx_next   = idx;
    cnt_next   = cnt;
    bwd_next   = bwd;
    cmd.op     = fci_pkg::OP_NONE;
    cmd.idx    = idx;
    cmd.seg    = bwd ? idx : idx - 1'b1;
    case (state)
      fci_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.op     = fci_pkg::OP_LOAD_IN;
          bwd_next   = 1'b0;
          state_next = fci_pkg::S_MX;
        end
      end
      fci_pkg::S_MX: begin
        cmd.op     = fci_pkg::OP_MUL_X;
        state_next = fci_pkg::S_MY;
      end
      fci_pkg::S_MY: begin
        cmd.op     = fci_pkg::OP_MUL_Y;
        state_next = fci_pkg::S_MT;
      end
      fci_pkg::S_MT: begin
        cmd.op     = fci_pkg::OP_MUL_T;
        state_next = fci_pkg::S_RC;
      end
      fci_pkg::S_RC: begin
        cmd.op     = fci_pkg::OP_REACH_CMP;
        state_next = fci_pkg::S_BR;
      end
      fci_pkg::S_BR: begin
        if (status.far) begin
          cmd.op     = fci_pkg::OP_WR_ROOT;
          cmd.idx    = '0;
          state_next = fci_pkg::S_SHIFT;
        end else begin
          cmd.op     = fci_pkg::OP_WR_TGT;
          cmd.idx    = LAST_IDX;
          idx_next   = LAST_IDX - 1'b1;
          bwd_next   = 1'b1;
          state_next = fci_pkg::S_RDO;
        end
      end
      fci_pkg::S_RDO: begin
        cmd.op     = fci_pkg::OP_READ;
        state_next = fci_pkg::S_RDB;
      end
      fci_pkg::S_RDB: begin
        cmd.op     = fci_pkg::OP_READ;
        cmd.idx    = base_idx;
        state_next = fci_pkg::S_LAT;
      end
      fci_pkg::S_LAT: begin
        if (status.far) begin
          cmd.op     = fci_pkg::OP_LATCH_BASE;
          state_next = fci_pkg::S_SCX;
        end else begin
          cmd.op     = fci_pkg::OP_LATCH_VEC;
          state_next = fci_pkg::S_SHIFT;
        end
      end
      fci_pkg::S_SHIFT: begin
        cmd.op = fci_pkg::OP_SHIFT;
        if (status.zero) begin
          state_next = fci_pkg::S_SCX;
        end else if (!status.mag_lo && !status.mag_hi) begin
          state_next = fci_pkg::S_SQX;
        end
      end
      fci_pkg::S_SQX: begin
        cmd.op     = fci_pkg::OP_MUL_X;
        state_next = fci_pkg::S_SQY;
      end
      fci_pkg::S_SQY: begin
        cmd.op     = fci_pkg::OP_MUL_Y;
        state_next = fci_pkg::S_SQI;
      end
      fci_pkg::S_SQI: begin
        cmd.op     = fci_pkg::OP_SQRT_INIT;
        cnt_next   = fci_pkg::CNT_W'(fci_pkg::SQRT_ITERS - 1);
        state_next = fci_pkg::S_SQRT;
      end
      fci_pkg::S_SQRT: begin
        cmd.op   = fci_pkg::OP_SQRT_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          state_next = fci_pkg::S_DVI;
        end
      end
      fci_pkg::S_DVI: begin
        cmd.op     = fci_pkg::OP_DIV_INIT;
        cnt_next   = fci_pkg::CNT_W'(fci_pkg::DIV_ITERS - 1);
        state_next = fci_pkg::S_DIV;
      end
      fci_pkg::S_DIV: begin
        cmd.op   = fci_pkg::OP_DIV_STEP;
        cnt_next = cnt - 1'b1;
        if (cnt == '0) begin
          // The straight chain normalises once and then places every joint
          // along that one direction.
          if (status.far) begin
            idx_next   = ONE_IDX;
            state_next = fci_pkg::S_RDB;
          end else begin
            state_next = fci_pkg::S_SCX;
          end
        end
      end
      fci_pkg::S_SCX: begin
        cmd.op     = fci_pkg::OP_SCALE_X;
        state_next = fci_pkg::S_SCY;
      end
      fci_pkg::S_SCY: begin
        cmd.op     = fci_pkg::OP_SCALE_Y;
        state_next = fci_pkg::S_WR;
      end
      fci_pkg::S_WR: begin
        cmd.op = fci_pkg::OP_WR_PLACE;
        if (bwd) begin
          if (idx == '0) begin
            state_next = fci_pkg::S_W0;
          end else begin
            idx_next   = idx - 1'b1;
            state_next = fci_pkg::S_RDO;
          end
        end else if (idx == LAST_IDX) begin
          idx_next   = '0;
          state_next = fci_pkg::S_ORD;
        end else begin
          idx_next   = idx + 1'b1;
          state_next = status.far ? fci_pkg::S_RDB : fci_pkg::S_RDO;
        end
      end
      fci_pkg::S_W0: begin
        cmd.op     = fci_pkg::OP_WR_ROOT;
        cmd.idx    = '0;
        idx_next   = ONE_IDX;
        bwd_next   = 1'b0;
        state_next = fci_pkg::S_RDO;
      end
      fci_pkg::S_ORD: begin
        cmd.op     = fci_pkg::OP_READ;
        state_next = fci_pkg::S_OLD;
      end
      fci_pkg::S_OLD: begin
        cmd.op     = fci_pkg::OP_OUT_LOAD;
        state_next = fci_pkg::S_OWAIT;
      end
      fci_pkg::S_OWAIT: begin
        if (out_ready) begin
          if (idx == LAST_IDX) begin
            state_next = fci_pkg::S_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = fci_pkg::S_ORD;
          end
        end
      end
      default: begin
        state_next = fci_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fci_pkg::S_IDLE;
      idx   <= '0;
      cnt   <= '0;
      bwd   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      cnt   <= cnt_next;
      bwd   <= bwd_next;
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while a result is offered");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == fci_pkg::S_MX))
    else $error("accepted item did not start the reach test");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && idx == LAST_IDX) |=> in_ready)
    else $error("block not idle after the last joint transfer");

  a_sqrt_then_div: assert property (@(posedge clk) disable iff (rst)
    (state == fci_pkg::S_SQRT && cnt == '0) |=> (state == fci_pkg::S_DVI))
    else $error("divider not started after the square root");

endmodule

// File: hw/rtl/fabrik_chain_iteration.sv
// Flow: the reach test first, then one normalisation and a placement per joint when out
// of reach, else 2*(JOINT_COUNT-1) normalisations, one per placed joint in each pass.
// A normalisation of a zero vector skips the root and divider; else it is a scaling of
// up to 30 one-bit shifts, a 32-step square root and a 17-step divider, all shared.
// Results leave one joint at a time; the next item is taken in the cycle after the last
// joint's transfer. Reset (rst, synchronous) zeroes all joints, each segment is 50.0.
module fabrik_chain_iteration #(
  parameter int JOINT_COUNT = fci_pkg::DEF_JOINT_COUNT,
  parameter int COORD_WIDTH = fci_pkg::DEF_COORD_WIDTH,
  localparam int S_TDATA_W  = ((4 * COORD_WIDTH + 7) / 8) * 8,
  localparam int M_TDATA_W  = ((fci_pkg::IDX_W + 2 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // root_x, root_y, target_x, target_y from the lowest bit up
  input  logic [S_TDATA_W-1:0]          s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // joint_index, joint_x, joint_y from the lowest bit up
  output logic [M_TDATA_W-1:0]          m_tdata,
  // stretched
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_we,
  input  logic [fci_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fci_pkg::SEG_W-1:0]     cfg_data
);

  localparam int W = COORD_WIDTH;

  fci_pkg::dp_cmd_t    cmd;
  fci_pkg::dp_status_t status;
  logic [fci_pkg::IDX_W-1:0] out_index;
  logic [W-1:0] out_x, out_y;

  fci_ctrl #(
    .JOINT_COUNT(JOINT_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .cmd       (cmd),
    .status    (status)
  );

  fci_datapath #(
    .JOINT_COUNT(JOINT_COUNT),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .root_x        (s_tdata[W-1:0]),
    .root_y        (s_tdata[2*W-1:W]),
    .target_x      (s_tdata[3*W-1:2*W]),
    .target_y      (s_tdata[4*W-1:3*W]),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_index     (out_index),
    .out_x         (out_x),
    .out_y         (out_y),
    .out_stretched (m_tuser),
    .out_last      (m_tlast)
  );

  assign m_tdata = M_TDATA_W'({out_y, out_x, out_index});

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for fabrik_chain_iteration: drives root/target pairs, predicts
// every joint position with a bit-exact FABRIK model and compares each joint transfer.
// Depends on fci_pkg and the fabrik_chain_iteration RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NJ = fci_pkg::DEF_JOINT_COUNT;
  localparam int CW = fci_pkg::DEF_COORD_WIDTH;
  localparam int SW = ((4 * CW + 7) / 8) * 8;
  localparam int MW = ((fci_pkg::IDX_W + 2 * CW + 7) / 8) * 8;
  localparam longint CMAX = (64'sd1 <<< (CW - 1)) - 1;
  localparam longint CMIN = -CMAX - 1;
  localparam int SEG0 = 0;
  localparam int SEG1 = 1;
  localparam int SEG2 = 2;
  localparam int SEG_BAD = 3;
  localparam longint LIMIT = 4000000;

  typedef struct {
    logic [fci_pkg::IDX_W-1:0] index;
    logic [CW-1:0]             x;
    logic [CW-1:0]             y;
    logic                      stretched;
    logic                      last;
  } joint_t;

  class joint_scoreboard;
    longint seg_len[fci_pkg::NUM_SEG_REGS];
    longint px[NJ];
    longint py[NJ];
    joint_t pending[$];
    int     mismatches;

    function void reset_state();
      foreach (seg_len[i]) seg_len[i] = fci_pkg::SEG_RESET;
      foreach (px[i]) begin
        px[i] = 0;
        py[i] = 0;
      end
    endfunction

    function void write_reg(int idx, logic [fci_pkg::SEG_W-1:0] v);
      if (idx < fci_pkg::NUM_SEG_REGS) seg_len[idx] = v;
    endfunction

    function longint len_of(int i);
      return (i < fci_pkg::NUM_SEG_REGS) ? seg_len[i] : 0;
    endfunction

    function longint clamp(longint v);
      if (v > CMAX) return CMAX;
      if (v < CMIN) return CMIN;
      return v;
    endfunction

    function longint magn(longint v);
      return v < 0 ? -v : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // Unit vector with 16 fractional bits; a zero vector stays zero.
    function void unit_dir(longint dx, longint dy, output longint ux, output longint uy);
      longint unsigned ax, ay, m, n;
      ax = magn(dx);
      ay = magn(dy);
      ux = 0;
      uy = 0;
      if (ax == 0 && ay == 0) return;
      m = ax > ay ? ax : ay;
      while (m < (64'd1 << 30)) begin
        ax <<= 1; ay <<= 1; m <<= 1;
      end
      while (m >= (64'd1 << 31)) begin
        ax >>= 1; ay >>= 1; m >>= 1;
      end
      n = int_sqrt(ax * ax + ay * ay);
      ux = longint'((ax << 16) / n);
      uy = longint'((ay << 16) / n);
      if (dx < 0) ux = -ux;
      if (dy < 0) uy = -uy;
    endfunction

    function longint offset(longint u, longint len);
      longint p;
      p = (magn(u) * len + 32768) >>> 16;
      return u < 0 ? -p : p;
    endfunction

    function void place(int dst, int src, longint ux, longint uy, longint len);
      px[dst] = clamp(px[src] + offset(ux, len));
      py[dst] = clamp(py[src] + offset(uy, len));
    endfunction

    function void note_item(longint rx, longint ry, longint tx, longint ty);
      longint dx, dy, ux, uy, total;
      longint unsigned ax, ay;
      bit far;
      joint_t j;
      dx = tx - rx;
      dy = ty - ry;
      total = 0;
      for (int i = 0; i < NJ - 1; i++) total += len_of(i);
      ax = magn(dx);
      ay = magn(dy);
      if (ax >= (64'd1 << 31) || ay >= (64'd1 << 31)) far = 1;
      else far = (ax * ax + ay * ay) > longint'(total * total);
      if (far) begin
        unit_dir(dx, dy, ux, uy);
        px[0] = rx;
        py[0] = ry;
        for (int i = 1; i < NJ; i++) place(i, i - 1, ux, uy, len_of(i - 1));
      end else begin
        px[NJ-1] = tx;
        py[NJ-1] = ty;
        for (int i = NJ - 2; i >= 0; i--) begin
          unit_dir(px[i] - px[i+1], py[i] - py[i+1], ux, uy);
          place(i, i + 1, ux, uy, len_of(i));
        end
        px[0] = rx;
        py[0] = ry;
        for (int i = 1; i < NJ; i++) begin
          unit_dir(px[i] - px[i-1], py[i] - py[i-1], ux, uy);
          place(i, i - 1, ux, uy, len_of(i - 1));
        end
      end
      for (int i = 0; i < NJ; i++) begin
        j.index = fci_pkg::IDX_W'(i);
        j.x = px[i][CW-1:0];
        j.y = py[i][CW-1:0];
        j.stretched = far;
        j.last = (i == NJ - 1);
        pending = {pending, j};
      end
    endfunction

    function void check_joint(joint_t got);
      joint_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected joint transfer: index %0d", got.index);
        return;
      end
      e = pending.pop_front();
      if (got.index !== e.index || got.x !== e.x || got.y !== e.y ||
          got.stretched !== e.stretched || got.last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"joint mismatch: exp idx %0d x %h y %h str %b last %b,",
                    " got idx %0d x %h y %h str %b last %b"},
                   e.index, e.x, e.y, e.stretched, e.last,
                   got.index, got.x, got.y, got.stretched, got.last);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_tvalid = 0, s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic m_tvalid, m_tready = 0, m_tuser, m_tlast;
  logic [MW-1:0] m_tdata;
  logic cfg_we = 0;
  logic [fci_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fci_pkg::SEG_W-1:0] cfg_data = '0;

  int send_idle_pct = 0, recv_stall_pct = 0;
  longint cycles = 0;
  joint_scoreboard sb;

  fabrik_chain_iteration uut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Receiver: random back-pressure and result checking.
  always @(posedge clk) begin
    joint_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.index = m_tdata[fci_pkg::IDX_W-1:0];
        got.x = m_tdata[fci_pkg::IDX_W +: CW];
        got.y = m_tdata[fci_pkg::IDX_W + CW +: CW];
        got.stretched = m_tuser;
        got.last = m_tlast;
        sb.check_joint(got);
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_item(logic [CW-1:0] rx, logic [CW-1:0] ry,
                           logic [CW-1:0] tx, logic [CW-1:0] ty);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    s_tvalid <= 1;
    s_tdata <= {rx, ry, tx, ty} == 0 ? '0 : SW'({ty, tx, ry, rx});
    do @(posedge clk); while (!s_tready);
    sb.note_item(longint'($signed(rx)), longint'($signed(ry)),
                 longint'($signed(tx)), longint'($signed(ty)));
    s_tvalid <= 0;
    // The block stays busy long after a transfer, so this cycle costs no throughput.
    @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [fci_pkg::SEG_W-1:0] v);
    cfg_we <= 1;
    cfg_index <= idx[fci_pkg::CFG_IDX_W-1:0];
    cfg_data <= v;
    @(posedge clk);
    sb.write_reg(idx, v);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // Waits until all joints are out, then lets the block settle.
  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_lengths(logic [fci_pkg::SEG_W-1:0] a, logic [fci_pkg::SEG_W-1:0] b,
                             logic [fci_pkg::SEG_W-1:0] c);
    drain();
    write_reg(SEG0, a);
    write_reg(SEG1, b);
    write_reg(SEG2, c);
  endtask

  function automatic logic [CW-1:0] rand_coord(int span);
    case ($urandom_range(3))
      0: return CW'($urandom);
      1: return CW'($signed($urandom_range(2 * span)) - span);
      2: return $urandom_range(1) ? CW'(CMAX - $urandom_range(span))
                                  : CW'(CMIN + $urandom_range(span));
      default: return CW'($signed($urandom_range(40000)) - 20000);
    endcase
  endfunction

  task automatic random_phase(int n);
    logic [CW-1:0] rx, ry;
    for (int i = 0; i < n; i++) begin
      rx = rand_coord(30000);
      ry = rand_coord(30000);
      // Mostly targets near the root, so the reachable passes get exercised.
      if ($urandom_range(3) != 0)
        send_item(rx, ry, rx + CW'($signed($urandom_range(80000)) - 40000),
                  ry + CW'($signed($urandom_range(80000)) - 40000));
      else
        send_item(rx, ry, rand_coord(30000), rand_coord(30000));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    repeat (2) @(posedge clk);
    rst <= 0;

    // Directed items.
    send_item('0, '0, '0, '0);
    send_item('0, '0, 24'd1000, 24'd2000);
    send_item('0, '0, 24'd500000, '0);
    send_item(24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    send_item(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF);
    send_item(24'h7FFFF0, '0, 24'h7FFFFF, 24'd10);
    send_item(24'h800010, 24'h800010, 24'h800000, 24'h800000);
    send_item(24'd100, 24'd100, 24'd100, 24'd100);
    send_item(24'hFFFF00, 24'd300, 24'd5000, 24'hFFE000);
    set_lengths('0, '0, '0);
    send_item(24'd77, 24'd77, 24'd77, 24'd77);
    send_item('0, '0, 24'd1, '0);
    set_lengths(16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_item(24'h7FFF00, 24'h7FFF00, 24'h7FFFFF, 24'h7FFFFF);
    send_item(24'h800000, '0, 24'h800100, 24'd300);
    send_item('0, '0, 24'd100000, 24'd100000);
    drain();
    write_reg(SEG_BAD, 16'd7);
    set_lengths(16'd256, 16'd12800, 16'd1);

    // Random phases with different idling patterns and lengths.
    send_idle_pct = 0;  recv_stall_pct = 0;  random_phase(70);
    set_lengths(fci_pkg::SEG_W'($urandom), fci_pkg::SEG_W'($urandom_range(40000)),
                fci_pkg::SEG_W'($urandom_range(3000)));
    send_idle_pct = 87; recv_stall_pct = 0;  random_phase(60);
    set_lengths(fci_pkg::SEG_RESET, fci_pkg::SEG_RESET, fci_pkg::SEG_RESET);
    send_idle_pct = 0;  recv_stall_pct = 87; random_phase(70);
    set_lengths(fci_pkg::SEG_W'($urandom), fci_pkg::SEG_W'($urandom),
                fci_pkg::SEG_W'($urandom));
    send_idle_pct = 21; recv_stall_pct = 21; random_phase(70);

    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
